>>> src/hrhl_pkg.sv
package hrhl_pkg;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_METHOD  = 3'd1,
        KIND_URI     = 3'd2,
        KIND_VERSION = 3'd3,
        KIND_HEADER  = 3'd4,
        KIND_COLON   = 3'd5,
        KIND_VALUE   = 3'd6,
        KIND_NUMBER  = 3'd7
    } t_kind;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] REQ_WORDS_MAX = 2'd3;

    typedef struct packed {
        logic       on_request_line;
        logic [1:0] request_words_seen;
        t_kind      open_token_kind;
        logic       last_token_colon;
    } t_lex_state;

    localparam t_lex_state LEX_STATE_RESET = '{
        on_request_line:    1'b1,
        request_words_seen: 2'd0,
        open_token_kind:    KIND_NONE,
        last_token_colon:   1'b0
    };

endpackage

>>> src/hrhl_if.sv
interface hrhl_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_message;

    modport source (output valid, output in_byte, output start_of_message, input ready);
    modport sink   (input valid, input in_byte, input start_of_message, output ready);
endinterface

interface hrhl_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] token_kind;
    logic       token_first;

    modport source (output valid, output out_byte, output token_kind, output token_first,
                    input ready);
    modport sink   (input valid, input out_byte, input token_kind, input token_first,
                    output ready);
endinterface

>>> src/http_request_header_lexer_top.sv
// a byte moves from the input register to the result register and waits in either while
// the output is not ready; throughput is one byte per cycle while the output is ready, set
// by the single classification pass between the registers
// the lexer state is updated in the same pass, so consecutive bytes need no bubble
// reset (i_rst_n low, synchronous) empties both registers and returns the lexer to the
// request line; a byte with start_of_message set restarts the lexer as well
module http_request_header_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrhl_req_if.sink    i_req,
    hrhl_tok_if.source  o_tok
);

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_som;

    // result register stage
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    hrhl_pkg::t_kind r_out_kind;
    logic            r_out_first;

    // lexer state, advanced once per classified byte
    hrhl_pkg::t_lex_state r_state;
    hrhl_pkg::t_lex_state n_state;
    hrhl_pkg::t_kind      n_kind;
    logic                 n_first;

    logic s_advance;
    logic s_in_take;

    // a byte moves into the result register when that register is free or being drained
    assign s_advance   = r_in_valid && (!r_out_valid || o_tok.ready);
    // input register takes a new transfer when empty or emptying this cycle
    assign i_req.ready = !r_in_valid || s_advance;
    assign s_in_take   = i_req.valid && i_req.ready;

    hrhl_classify u_classify (
        .i_byte       (r_in_byte),
        .i_som        (r_in_som),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_kind       (n_kind),
        .o_first      (n_first)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= hrhl_pkg::LEX_STATE_RESET;
        end else begin
            if (s_in_take) begin
                r_in_valid <= 1'b1;
            end else if (s_advance) begin
                r_in_valid <= 1'b0;
            end

            if (s_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_byte <= i_req.in_byte;
            r_in_som  <= i_req.start_of_message;
        end
        if (s_advance) begin
            r_out_byte  <= r_in_byte;
            r_out_kind  <= n_kind;
            r_out_first <= n_first;
        end
    end

    assign o_tok.valid       = r_out_valid;
    assign o_tok.out_byte    = r_out_byte;
    assign o_tok.token_kind  = r_out_kind;
    assign o_tok.token_first = r_out_first;

    // a token start always carries a real kind
    a_first_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_first |-> r_out_kind != hrhl_pkg::KIND_NONE)
        else $error("token start without a kind");

    // once in the header lines, only a restart brings back the request line
    a_stay_in_headers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_advance && !r_in_som && !r_state.on_request_line |=> !r_state.on_request_line)
        else $error("left header lines without a restart");

    // on the request line an open token is only ever a request word
    a_request_open_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.on_request_line |->
            (r_state.open_token_kind == hrhl_pkg::KIND_NONE
             || r_state.open_token_kind == hrhl_pkg::KIND_METHOD
             || r_state.open_token_kind == hrhl_pkg::KIND_URI
             || r_state.open_token_kind == hrhl_pkg::KIND_VERSION))
        else $error("bad open token on the request line");

    // a colon never stays open as a token
    a_colon_not_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_advance && n_kind == hrhl_pkg::KIND_COLON |=>
            r_state.open_token_kind == hrhl_pkg::KIND_NONE && r_state.last_token_colon)
        else $error("colon left a token open");

endmodule

>>> src/hrhl_classify.sv
module hrhl_classify (
    input  logic [7:0]          i_byte,
    input  logic                i_som,
    input  hrhl_pkg::t_lex_state i_state,
    output hrhl_pkg::t_lex_state o_next_state,
    output hrhl_pkg::t_kind     o_kind,
    output logic                o_first
);

    always_comb begin
        hrhl_pkg::t_lex_state st;
        hrhl_pkg::t_kind      kind;
        logic                 first;
        logic                 fresh;
        logic                 is_digit;
        logic                 is_eol;
        logic [1:0]           words_inc;

        st        = i_som ? hrhl_pkg::LEX_STATE_RESET : i_state;
        kind      = hrhl_pkg::KIND_NONE;
        first     = 1'b0;
        fresh     = 1'b1;
        is_digit  = (i_byte >= hrhl_pkg::CH_ZERO) && (i_byte <= hrhl_pkg::CH_NINE);
        is_eol    = (i_byte == hrhl_pkg::CH_CR) || (i_byte == hrhl_pkg::CH_LF);
        words_inc = st.request_words_seen + 2'd1;

        if (st.on_request_line) begin
            if (i_byte == hrhl_pkg::CH_CR) begin
                st.on_request_line = 1'b0;
                st.open_token_kind = hrhl_pkg::KIND_NONE;
            end else if (i_byte == hrhl_pkg::CH_SPACE) begin
                st.open_token_kind = hrhl_pkg::KIND_NONE;
            end else if (st.open_token_kind != hrhl_pkg::KIND_NONE) begin
                kind = st.open_token_kind;
            end else if (st.request_words_seen < hrhl_pkg::REQ_WORDS_MAX) begin
                st.request_words_seen = words_inc;
                kind                  = hrhl_pkg::t_kind'({1'b0, words_inc});
                first                 = 1'b1;
                st.open_token_kind    = kind;
            end
        end else begin
            // continue or close the open token
            case (st.open_token_kind)
                hrhl_pkg::KIND_VALUE: begin
                    if (is_eol) begin
                        st.open_token_kind = hrhl_pkg::KIND_NONE;
                    end else begin
                        kind  = hrhl_pkg::KIND_VALUE;
                        fresh = 1'b0;
                    end
                end
                hrhl_pkg::KIND_HEADER: begin
                    if (is_eol || i_byte == hrhl_pkg::CH_SPACE
                            || i_byte == hrhl_pkg::CH_COLON) begin
                        st.open_token_kind = hrhl_pkg::KIND_NONE;
                    end else begin
                        kind  = hrhl_pkg::KIND_HEADER;
                        fresh = 1'b0;
                    end
                end
                hrhl_pkg::KIND_NUMBER: begin
                    if (is_digit) begin
                        kind  = hrhl_pkg::KIND_NUMBER;
                        fresh = 1'b0;
                    end else begin
                        st.open_token_kind = hrhl_pkg::KIND_NONE;
                    end
                end
                default: begin
                    st.open_token_kind = hrhl_pkg::KIND_NONE;
                end
            endcase

            if (fresh) begin
                if (is_eol || i_byte == hrhl_pkg::CH_SPACE) begin
                    kind = hrhl_pkg::KIND_NONE;
                end else if (i_byte == hrhl_pkg::CH_COLON) begin
                    kind                = hrhl_pkg::KIND_COLON;
                    first               = 1'b1;
                    st.last_token_colon = 1'b1;
                end else if (is_digit) begin
                    kind                = hrhl_pkg::KIND_NUMBER;
                    first               = 1'b1;
                    st.open_token_kind  = hrhl_pkg::KIND_NUMBER;
                    st.last_token_colon = 1'b0;
                end else begin
                    kind = st.last_token_colon ? hrhl_pkg::KIND_VALUE
                                               : hrhl_pkg::KIND_HEADER;
                    first               = 1'b1;
                    st.open_token_kind  = kind;
                    st.last_token_colon = 1'b0;
                end
            end
        end

        o_next_state = st;
        o_kind       = kind;
        o_first      = first;
    end

endmodule
